FILE: rtl/tlsm_pkg.sv
// Shared types and constants of the two-list sorted merge block.
package tlsm_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int DATA_W     = 32;
    localparam int FUNC_W     = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH_A = 2'd0,
        FUNC_PUSH_B = 2'd1,
        FUNC_MERGE  = 2'd2
    } t_func;

    // Controller to datapath.
    typedef struct packed {
        logic push_a;       // append request value to list A
        logic push_b;       // append request value to list B
        logic merge_start;  // rewind both read indices
        logic pick;         // compare heads, load output register, advance
        logic clear;        // empty both lists
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic any_elem;     // at least one list holds an element
        logic out_free;     // output register can take a result this cycle
        logic pick_last;    // the pending pick is the final element
    } t_dp_sts;

endpackage

FILE: rtl/tlsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tlsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/tlsm_ctrl.sv
// Controller state machine: decodes requests and sequences the merge.
module tlsm_ctrl
    import tlsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic [FUNC_W-1:0] i_req_func,
    output logic              o_req_ready,
    output t_dp_cmd           o_cmd,
    input  t_dp_sts           i_sts
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_PICK = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   req_fire;

    assign o_req_ready = (r_state == ST_IDLE);
    assign req_fire    = i_req_valid && o_req_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    unique case (i_req_func)
                        FUNC_PUSH_A: o_cmd.push_a = 1'b1;
                        FUNC_PUSH_B: o_cmd.push_b = 1'b1;
                        FUNC_MERGE: begin
                            if (i_sts.any_elem) begin
                                o_cmd.merge_start = 1'b1;
                                n_state           = ST_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                n_state = ST_PICK;
            end
            ST_PICK: begin
                if (i_sts.out_free) begin
                    o_cmd.pick = 1'b1;
                    if (i_sts.pick_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/tlsm_dp.sv
// Datapath: list memories, fill counts, read indices, head compare, output register.
module tlsm_dp
    import tlsm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic signed [DATA_W-1:0] i_value,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_out_data,
    output logic                     o_out_last
);

    logic [CNT_W-1:0]         r_cnt_a, r_cnt_b;
    logic [CNT_W-1:0]         r_idx_a, r_idx_b;
    logic [DATA_W-1:0]        head_a, head_b;
    logic                     a_left, b_left, a_full, b_full, take_a;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_data;
    logic                     r_out_last;

    assign a_full = (r_cnt_a == CNT_W'(LIST_DEPTH));
    assign b_full = (r_cnt_b == CNT_W'(LIST_DEPTH));

    tlsm_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH)) u_ram_a (
        .i_clk  (i_clk),
        .i_we   (i_cmd.push_a && !a_full),
        .i_waddr(r_cnt_a[ADDR_W-1:0]),
        .i_wdata(i_value),
        .i_raddr(r_idx_a[ADDR_W-1:0]),
        .o_rdata(head_a)
    );

    tlsm_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH)) u_ram_b (
        .i_clk  (i_clk),
        .i_we   (i_cmd.push_b && !b_full),
        .i_waddr(r_cnt_b[ADDR_W-1:0]),
        .i_wdata(i_value),
        .i_raddr(r_idx_b[ADDR_W-1:0]),
        .o_rdata(head_b)
    );

    assign a_left = (r_idx_a != r_cnt_a);
    assign b_left = (r_idx_b != r_cnt_b);
    // Take A only on strictly smaller head; ties go to B.
    assign take_a = a_left && (!b_left || ($signed(head_a) < $signed(head_b)));

    assign o_sts.any_elem  = (r_cnt_a != '0) || (r_cnt_b != '0);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_sts.pick_last = take_a ? ((r_idx_a + 1'b1 == r_cnt_a) && !b_left)
                                    : ((r_idx_b + 1'b1 == r_cnt_b) && !a_left);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_idx_a <= '0;
            r_idx_b <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_cnt_a <= '0;
                r_cnt_b <= '0;
            end else begin
                if (i_cmd.push_a && !a_full) r_cnt_a <= r_cnt_a + 1'b1;
                if (i_cmd.push_b && !b_full) r_cnt_b <= r_cnt_b + 1'b1;
            end
            if (i_cmd.merge_start) begin
                r_idx_a <= '0;
                r_idx_b <= '0;
            end else if (i_cmd.pick) begin
                if (take_a) r_idx_a <= r_idx_a + 1'b1;
                else        r_idx_b <= r_idx_b + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.pick) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pick) begin
            r_out_data <= take_a ? $signed(head_a) : $signed(head_b);
            r_out_last <= o_sts.pick_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= CNT_W'(LIST_DEPTH)) && (r_cnt_b <= CNT_W'(LIST_DEPTH)))
        else $error("list count beyond depth");
    a_pick_has_elem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pick |-> (a_left || b_left))
        else $error("pick with both lists exhausted");
    a_pick_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pick |-> o_sts.out_free)
        else $error("pick overwrites an untaken result");
    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pick && o_sts.pick_last) |=> (r_cnt_a == '0) && (r_cnt_b == '0))
        else $error("lists not emptied after final element");
`endif

endmodule

FILE: rtl/two_list_sorted_merge_top.sv
// Top level of the two-list sorted merge block.
//
//  channel   dir  handshake                       payload
//  -------   ---  ------------------------------  ------------------------------------
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata: value; tuser: func
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata: merged_value; tlast: last
//
//  A push request leaves the controller idle, so the block stays ready for further requests.
//  A merge request steps through a read state and then a compare-and-load state
//  for each result, since each list RAM has a registered read port. A merge of
//  two empty lists emits nothing and leaves the block idle.
//  Reset is synchronous, active low, and empties both lists; no clearing pass.
//  A stalled m_axis holds the merge in its compare step; s_axis stays stalled
//  until the final element sits in the output register.
module two_list_sorted_merge_top
    import tlsm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic signed [DATA_W-1:0] s_axis_tdata,   // [31:0] value
    input  logic [FUNC_W-1:0]        s_axis_tuser,   // [1:0] func
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic signed [DATA_W-1:0] m_axis_tdata,   // [31:0] merged_value
    output logic                     m_axis_tlast
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Decode requests and step the merge one element at a time.
    tlsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(s_axis_tvalid),
        .i_req_func (s_axis_tuser),
        .o_req_ready(s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // Hold both lists and drive results through the output register.
    tlsm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_value    (s_axis_tdata),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .o_out_data (m_axis_tdata),
        .o_out_last (m_axis_tlast)
    );

endmodule

FILE: sim/two_list_sorted_merge_top_tb.sv
// Self-checking testbench for the two-list sorted merge block.
`timescale 1ns / 100ps

module two_list_sorted_merge_top_tb;
    import tlsm_pkg::*;

    // Selector code the block must ignore.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int  TOTAL_REQUESTS  = 150;
    localparam int  SETTLE_CYCLES   = 16;
    localparam int  CYCLE_LIMIT     = 300000;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_merged;

    // Keeps its own copy of both lists, predicts each merge at the moment
    // the merge request is accepted, and checks results in order.
    class sorted_merge_scoreboard;
        logic signed [DATA_W-1:0] list_a[$];
        logic signed [DATA_W-1:0] list_b[$];
        t_merged merged_expected[$];
        int kept_pushes;
        int dropped_pushes;
        int ignored;
        int merges;
        int results_seen;
        int errors;

        function new();
            kept_pushes    = 0;
            dropped_pushes = 0;
            ignored        = 0;
            merges         = 0;
            results_seen   = 0;
            errors         = 0;
        endfunction

        function int pending();
            return merged_expected.size();
        endfunction

        function int requests_seen();
            return kept_pushes + dropped_pushes + ignored + merges;
        endfunction

        // Take A only when its head is strictly smaller; ties come from B.
        function void predict_merge();
            t_merged elem;
            int total;
            int n;
            total = list_a.size() + list_b.size();
            n = 0;
            while (list_a.size() > 0 || list_b.size() > 0) begin
                if (list_a.size() > 0 && list_b.size() > 0) begin
                    if (list_a[0] < list_b[0]) elem.value = list_a.pop_front();
                    else elem.value = list_b.pop_front();
                end else if (list_a.size() > 0) begin
                    elem.value = list_a.pop_front();
                end else begin
                    elem.value = list_b.pop_front();
                end
                n++;
                elem.last = (n == total);
                merged_expected.insert(merged_expected.size(), elem);
            end
        endfunction

        function void note_request(logic [FUNC_W-1:0] func, logic signed [DATA_W-1:0] value);
            case (func)
                FUNC_PUSH_A: begin
                    if (list_a.size() < LIST_DEPTH) begin
                        list_a.insert(list_a.size(), value);
                        kept_pushes++;
                    end else begin
                        dropped_pushes++;
                    end
                end
                FUNC_PUSH_B: begin
                    if (list_b.size() < LIST_DEPTH) begin
                        list_b.insert(list_b.size(), value);
                        kept_pushes++;
                    end else begin
                        dropped_pushes++;
                    end
                end
                FUNC_MERGE: begin
                    merges++;
                    predict_merge();
                end
                default: ignored++;
            endcase
        endfunction

        function void check_result(logic signed [DATA_W-1:0] value, logic last);
            t_merged exp_elem;
            results_seen++;
            if (merged_expected.size() == 0) begin
                $error("unexpected result: merged_value=%0d last=%0b", value, last);
                errors++;
                return;
            end
            exp_elem = merged_expected.pop_front();
            if (value !== exp_elem.value) begin
                $error("merged_value mismatch: expected %0d, actual %0d",
                       exp_elem.value, value);
                errors++;
            end
            if (last !== exp_elem.last) begin
                $error("last mismatch: expected %0b, actual %0b", exp_elem.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n       = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic signed [DATA_W-1:0] s_axis_tdata  = '0;   // [31:0] value
    logic [FUNC_W-1:0]        s_axis_tuser  = '0;   // [1:0] func
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic signed [DATA_W-1:0] m_axis_tdata;         // [31:0] merged_value
    logic                     m_axis_tlast;

    sorted_merge_scoreboard sb = new();

    int cycle_count = 0;
    int burst_left  = 0;
    int stall_mode  = 0;
    int mode_left   = 0;

    two_list_sorted_merge_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Bound the run; a hang anywhere ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, sb.pending());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver back-pressure: switch between always-ready, coin-flip and
    // long-stall stretches so stalls hit both the compare and the last result.
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(5, 60);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Check every accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    // Present one request and hold it until accepted. The sender runs in
    // bursts; between bursts drop valid for a random gap.
    task automatic send_request(input logic [FUNC_W-1:0] func,
                                input logic signed [DATA_W-1:0] value);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(func, value);
    endtask

    // Hold off the sender until every predicted result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    // Next element of a generated list: full-range noise (mode 0), dense
    // ascending with many ties (modes 1, 2) or widely spaced ascending.
    function automatic logic signed [DATA_W-1:0] next_elem(input int mode,
                                                           inout longint level);
        longint step;
        if (mode == 0) return $urandom;
        if (mode <= 2) step = $urandom_range(0, 2);
        else step = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 1 << 24);
        level = level + step;
        if (level > 64'sd2147483647) level = 64'sd2147483647;
        return level[DATA_W-1:0];
    endfunction

    // Load na elements into A and nb into B in random interleaving, with
    // stray unused selectors, then merge.
    task automatic run_sequence(input int na, input int nb);
        logic signed [DATA_W-1:0] vals_a[$];
        logic signed [DATA_W-1:0] vals_b[$];
        int mode;
        int ia;
        int ib;
        longint base;
        longint level_a;
        longint level_b;
        mode = $urandom_range(0, 5);
        case ($urandom_range(0, 7))
            0:       base = -64'sd2147483648;
            1:       base = 64'sd2147483647 - $urandom_range(0, 40);
            default: base = longint'(int'($urandom));
        endcase
        // Same start in both lists so dense lists collide on equal values.
        level_a = base;
        level_b = base;
        for (int k = 0; k < na; k++) vals_a.insert(vals_a.size(), next_elem(mode, level_a));
        for (int k = 0; k < nb; k++) vals_b.insert(vals_b.size(), next_elem(mode, level_b));
        ia = 0;
        ib = 0;
        while (ia < na || ib < nb) begin
            if ($urandom_range(0, 11) == 0) send_request(FUNC_UNUSED, $urandom);
            if (ib == nb || (ia < na && $urandom_range(0, 1) == 1)) begin
                send_request(FUNC_PUSH_A, vals_a[ia]);
                ia++;
            end else begin
                send_request(FUNC_PUSH_B, vals_b[ib]);
                ib++;
            end
        end
        send_request(FUNC_MERGE, $urandom);
    endtask

    initial begin
        int seq_idx;
        int na;
        int nb;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: merge of two empty lists emits nothing.
        send_request(FUNC_MERGE, VAL_MAX);
        // Unused selector leaves the lists alone.
        send_request(FUNC_UNUSED, 32'hFFFF_FFFF);
        // Extremes with ties at the minimum, zero and maximum: ties take B.
        send_request(FUNC_PUSH_A, VAL_MIN);
        send_request(FUNC_PUSH_B, VAL_MIN);
        send_request(FUNC_PUSH_A, -32'sd1);
        send_request(FUNC_PUSH_B, 32'sd0);
        send_request(FUNC_PUSH_A, 32'sd0);
        send_request(FUNC_PUSH_B, 32'sd0);
        send_request(FUNC_PUSH_A, VAL_MAX);
        send_request(FUNC_PUSH_B, VAL_MAX);
        send_request(FUNC_MERGE, 32'h0000_0000);
        // Lists out of order: plain head-compare merge.
        send_request(FUNC_PUSH_A, 32'sd5);
        send_request(FUNC_PUSH_A, -32'sd3);
        send_request(FUNC_PUSH_B, 32'sd2);
        send_request(FUNC_MERGE, 32'h5555_5555);
        // Only B holds data, then only A.
        send_request(FUNC_PUSH_B, 32'sd7);
        send_request(FUNC_MERGE, 32'hAAAA_AAAA);
        send_request(FUNC_PUSH_A, -32'sd7);
        send_request(FUNC_MERGE, 32'h0000_0000);
        // Unused selector in the middle of a load.
        send_request(FUNC_PUSH_A, 32'sd1);
        send_request(FUNC_UNUSED, VAL_MIN);
        send_request(FUNC_MERGE, 32'h0000_0000);

        // Random: mostly short well-formed loads, some overfilling a list.
        seq_idx = 0;
        while (sb.requests_seen() < TOTAL_REQUESTS) begin
            na = $urandom_range(0, 6);
            nb = $urandom_range(0, 6);
            if (seq_idx == 0) begin
                na = $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 3);
            end else if (seq_idx == 1) begin
                nb = $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 3);
            end else if ($urandom_range(0, 11) == 0) begin
                if ($urandom_range(0, 1) == 1) na = $urandom_range(20, LIST_DEPTH + 4);
                else nb = $urandom_range(20, LIST_DEPTH + 4);
            end
            run_sequence(na, nb);
            // Let the block run dry at least once, then now and then.
            if (seq_idx == 2 || $urandom_range(0, 4) == 0) drain_results();
            seq_idx++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d stored pushes, %0d pushes to full lists, %0d unused selectors",
                 sb.kept_pushes, sb.dropped_pushes, sb.ignored);
        $display("and %0d merges; %0d merged elements checked in %0d cycles.",
                 sb.merges, sb.results_seen, cycle_count);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
